### src/mf3_pkg.sv
package mf3_pkg;

  // Line geometry
  localparam int unsigned MaxLineLength   = 4096;
  localparam int unsigned PosW            = $clog2(MaxLineLength);
  localparam int unsigned CfgW            = 13;
  localparam int unsigned LineLengthReset = 640;
  localparam int unsigned MinLineLength   = 3;

  // Pixel and result queue
  localparam int unsigned PixW      = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef logic [PixW-1:0] pix_t;
  typedef logic [8:0][PixW-1:0] win_t;

  // One result item as held in the output queue
  typedef struct packed {
    pix_t pix;
    logic last;
  } res_t;

  // Control of the item held between the input side and the median network
  typedef struct packed {
    logic vld;
    logic emit0;   // result for the previous position
    logic emit1;   // extra result for the last column of a line
    logic border;  // previous position is copied, not filtered
  } job_ctl_t;

  // Compare and exchange: returns {lower, higher}
  function automatic logic [2*PixW-1:0] cas(input pix_t a, input pix_t b);
    cas = (a > b) ? {b, a} : {a, b};
  endfunction

  // Median of nine by a fixed 19-step exchange network
  function automatic pix_t median9(input win_t w);
    win_t p;
    p = w;
    {p[1], p[2]} = cas(p[1], p[2]);
    {p[4], p[5]} = cas(p[4], p[5]);
    {p[7], p[8]} = cas(p[7], p[8]);
    {p[0], p[1]} = cas(p[0], p[1]);
    {p[3], p[4]} = cas(p[3], p[4]);
    {p[6], p[7]} = cas(p[6], p[7]);
    {p[1], p[2]} = cas(p[1], p[2]);
    {p[4], p[5]} = cas(p[4], p[5]);
    {p[7], p[8]} = cas(p[7], p[8]);
    {p[0], p[3]} = cas(p[0], p[3]);
    {p[5], p[8]} = cas(p[5], p[8]);
    {p[4], p[7]} = cas(p[4], p[7]);
    {p[3], p[6]} = cas(p[3], p[6]);
    {p[1], p[4]} = cas(p[1], p[4]);
    {p[2], p[5]} = cas(p[2], p[5]);
    {p[4], p[7]} = cas(p[4], p[7]);
    {p[4], p[2]} = cas(p[4], p[2]);
    {p[6], p[4]} = cas(p[6], p[4]);
    {p[4], p[2]} = cas(p[4], p[2]);
    median9 = p[4];
  endfunction

endpackage

### src/median_filter_3x3.sv
// A result passes from the input register, through the median network, into the output
// queue, and leaves from there.
// Throughput: one column per cycle; the last column of a line gives two items, which the
// four-entry output queue absorbs, so a stall only follows when the sink falls behind.
// Reset (rst_ni low, asynchronous): line_length returns to 640, position and queue clear.
module median_filter_3x3
  import mf3_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration: line_length
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  // Column input
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // upper_pixel, center_pixel, lower_pixel
  input  logic            s_axis_tuser,   // edge_line
  // Result output
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // filtered_pixel
  output logic            m_axis_tlast    // line_done
);

  logic [CfgW-1:0] len_q;
  logic [PosW-1:0] pos_q, pos_d, lim;
  logic            held_edge_q;
  pix_t            old_q [3];
  pix_t            new_q [3];
  pix_t            col   [3];
  logic            s_acc, m_acc, last_col;

  job_ctl_t        job_q, job_d;
  win_t            win_q;

  res_t            fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d, job_n, n_push, n_in;
  res_t            res0, res1;

  assign col[0] = s_axis_tdata[7:0];
  assign col[1] = s_axis_tdata[15:8];
  assign col[2] = s_axis_tdata[23:16];

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= CfgW'(LineLengthReset);
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // Last position of the line, with the length clamped to its legal range
  always_comb begin
    if (len_q < CfgW'(MinLineLength)) begin
      lim = PosW'(MinLineLength - 1);
    end else if (len_q > CfgW'(MaxLineLength)) begin
      lim = PosW'(MaxLineLength - 1);
    end else begin
      lim = PosW'(len_q - CfgW'(1));
    end
  end

  assign last_col = (pos_q >= lim);
  assign pos_d    = last_col ? '0 : pos_q + PosW'(1);

  // Position and edge flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      held_edge_q <= 1'b0;
    end else if (s_acc) begin
      pos_q       <= pos_d;
      held_edge_q <= s_axis_tuser;
    end
  end

  // Column history and window capture
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      for (int i = 0; i < 3; i++) begin
        old_q[i] <= new_q[i];
        new_q[i] <= col[i];
      end
      win_q <= {col[2], col[1], col[0], new_q[2], new_q[1], new_q[0],
                old_q[2], old_q[1], old_q[0]};
    end
  end

  // Job control for the median stage
  always_comb begin
    job_d.vld    = s_acc;
    job_d.emit0  = s_acc && (pos_q != '0);
    job_d.emit1  = s_acc && last_col;
    job_d.border = (pos_q == PosW'(1)) || held_edge_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '0;
    end else begin
      job_q <= job_d;
    end
  end

  // Median network and result forming; window index 4 is the previous center pixel
  always_comb begin
    res0.pix  = job_q.border ? win_q[4] : median9(win_q);
    res0.last = 1'b0;
    res1.pix  = win_q[7];
    res1.last = 1'b1;
  end

  assign job_n  = job_q.vld ? CntW'(job_q.emit0) + CntW'(job_q.emit1) : '0;
  assign n_push = job_n;

  // Results the offered column would cause
  assign n_in = CntW'(pos_q != '0) + CntW'(last_col);

  // Room for the offered column's results beyond what is queued or still in the median stage
  assign s_axis_tready = (cnt_q + job_n + n_in) <= CntW'(FifoDepth);

  // Output queue storage
  always_ff @(posedge clk_i) begin
    if (job_q.vld && job_q.emit0) begin
      fifo_q[wr_ptr_q] <= res0;
      if (job_q.emit1) begin
        fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
      end
    end else if (job_q.vld && job_q.emit1) begin
      fifo_q[wr_ptr_q] <= res1;
    end
  end

  assign cnt_d = cnt_q + n_push - CntW'(m_acc);

  // Output queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (m_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q].pix;
  assign m_axis_tlast  = fifo_q[rd_ptr_q].last;

  // Checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + job_n) <= CntW'(FifoDepth))
    else $error("output queue overflow");

  a_first_col_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (pos_q == '0) |=> !job_q.emit0)
    else $error("result produced for first column");

  a_last_col_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && last_col |=> job_q.emit0 && job_q.emit1 && (pos_q == '0))
    else $error("line end not handled");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> (cnt_q != '0))
    else $error("pop from empty queue");

endmodule
